// File: hdl/assert_macros.svh
// Assertion helpers shared by the heightmap normal engine modules.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HNN_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hnn assertion failed");

// Next-cycle implication.
`define HNN_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hnn assertion failed");

`endif

// File: hdl/hnn_pkg.sv
// ----------------------------------------------------------------------------
// hnn_pkg
// Types and constants of the heightmap node normal engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hnn_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  localparam int IDX_W = 9;
  localparam int CFG_W = 32;

  localparam logic [1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [1:0] CFG_GRID_ROWS = 2'd1;
  localparam logic [1:0] CFG_INV_COL   = 2'd2;
  localparam logic [1:0] CFG_INV_ROW   = 2'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [14:0] Q14_ONE  = 15'd16384;
  localparam logic [63:0] UNIT_Q24 = 64'd16777216;

  typedef struct packed {
    logic               func;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
    logic signed [31:0] cell_height;
  } hnn_in_t;

  typedef struct packed {
    logic signed [31:0] node_height;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
  } hnn_out_t;

  // request to the shared root / divide unit
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } hnn_sd_req_t;

endpackage

`default_nettype wire

// File: hdl/heightmap_node_normal_engine.sv
// ----------------------------------------------------------------------------
// heightmap_node_normal_engine
// Node height and unit surface normal from a stored cell elevation grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): func = load writes one cell
// (ignored outside the active grid) and returns no result. func =
// query returns one item on out_valid/out_stall/out_data: the node height
// (Q24.8) and the normal (Q1.14).
// A query runs on a sequencer: cell reads through the single RAM read port
// (twelve cells), difference and scaling, normalizing (a right shift of all
// three components until they fit, then a final check), 3 squares on the shared
// multiplier, the square root and three divides. out_valid rises as the state
// returns to idle, so the next item can be taken in the same cycle. in_stall
// stays high while a query is in flight.
// A finished result sits in the output register; if the receiver stalls,
// the next query completes and then waits until that register is taken.
// The user writes configuration (cfg_we/cfg_index/cfg_wdata) only while idle;
// the block does not enforce it. Reset (rst_n low, synchronous) restores
// 256 x 256 cells and unit spacings; cell contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module heightmap_node_normal_engine #(
  parameter int MAX_COLS = hnn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hnn_pkg::MAX_ROWS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire hnn_pkg::hnn_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output hnn_pkg::hnn_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [hnn_pkg::CFG_W-1:0] cfg_wdata
);
  import hnn_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_FETCH = 10'b00_0000_0010,
    ST_DIFF  = 10'b00_0000_0100,
    ST_MULX  = 10'b00_0000_1000,
    ST_MULY  = 10'b00_0001_0000,
    ST_NORM  = 10'b00_0010_0000,
    ST_SQR   = 10'b00_0100_0000,
    ST_SQRT  = 10'b00_1000_0000,
    ST_DIV   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [8:0]  grid_cols_r, grid_rows_r;
  logic [31:0] inv_col_r, inv_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= 9'd256;
      grid_rows_r <= 9'd256;
      inv_col_r   <= 32'd65536;
      inv_row_r   <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata[8:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[8:0];
        CFG_INV_COL:   inv_col_r   <= cfg_wdata;
        CFG_INV_ROW:   inv_row_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [8:0] cols_a, rows_a;
  always_comb begin
    if (grid_cols_r == 9'd0) cols_a = 9'd1;
    else if (32'(grid_cols_r) > 32'(MAX_COLS)) cols_a = 9'(MAX_COLS);
    else cols_a = grid_cols_r;
    if (grid_rows_r == 9'd0) rows_a = 9'd1;
    else if (32'(grid_rows_r) > 32'(MAX_ROWS)) rows_a = 9'(MAX_ROWS);
    else rows_a = grid_rows_r;
  end

  logic in_fire;
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // query coordinates, clamped at accept
  logic [8:0] qc_r, qr_r, ip1_r, jp1_r;
  logic [8:0] qc_cl, qr_cl;
  assign qc_cl = (in_data.col > cols_a) ? cols_a : in_data.col;
  assign qr_cl = (in_data.row > rows_a) ? rows_a : in_data.row;

  // cell RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  assign ram_we = in_fire && (in_data.func == FUNC_LOAD) &&
                  (in_data.col < cols_a) && (in_data.row < rows_a);
  assign ram_waddr = AW'(32'(in_data.row) * 32'(MAX_COLS) + 32'(in_data.col));

  hnn_cell_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.cell_height),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fetch sequencing: node = fcnt[3:2], corner = fcnt[1:0]
  logic [3:0] fcnt_r;
  logic [8:0] ni, nj, ci, cj, lo_c, hi_c, lo_r, hi_r;
  always_comb begin
    case (fcnt_r[3:2])
      2'd1:    begin ni = ip1_r; nj = qr_r;  end
      2'd2:    begin ni = qc_r;  nj = jp1_r; end
      default: begin ni = qc_r;  nj = qr_r;  end
    endcase
    lo_c = (ni > 9'd0) ? ni - 9'd1 : 9'd0;
    hi_c = (ni < cols_a) ? ni : cols_a - 9'd1;
    lo_r = (nj > 9'd0) ? nj - 9'd1 : 9'd0;
    hi_r = (nj < rows_a) ? nj : rows_a - 9'd1;
    ci   = fcnt_r[0] ? hi_c : lo_c;
    cj   = fcnt_r[1] ? hi_r : lo_r;
  end
  assign ram_raddr = AW'(32'(cj) * 32'(MAX_COLS) + 32'(ci));

  logic              acc_en_r;
  logic [1:0]        acc_node_r;
  logic signed [33:0] sum0_r, sum1_r, sum2_r;

  // datapath registers
  logic signed [31:0] z0_r;
  logic [32:0]        adx_r, ady_r;
  logic               posx_r, posy_r;
  logic [63:0]        ax_r, ay_r, az_r;
  logic [1:0]         sub_r;
  logic [61:0]        ssum_r;
  logic [30:0]        root_r;
  logic [14:0]        qx_r, qy_r, qz_r;
  logic               go_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [29:0] vsel;
  always_comb begin
    case (sub_r)
      2'd1:    vsel = ay_r[29:0];
      2'd2:    vsel = az_r[29:0];
      default: vsel = ax_r[29:0];
    endcase
    case (state_r)
      ST_MULX: begin mul_a = adx_r[31:0]; mul_b = inv_col_r; end
      ST_MULY: begin mul_a = ady_r[31:0]; mul_b = inv_row_r; end
      default: begin mul_a = {2'b0, vsel}; mul_b = {2'b0, vsel}; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // node heights and differences
  logic signed [31:0] z0_c, z1_c, z2_c;
  logic signed [32:0] dx_c, dy_c;
  assign z0_c = 32'(sum0_r >>> 2);
  assign z1_c = 32'(sum1_r >>> 2);
  assign z2_c = 32'(sum2_r >>> 2);
  assign dx_c = 33'(z1_c) - 33'(z0_c);
  assign dy_c = 33'(z2_c) - 33'(z0_c);

  logic big;
  assign big = (|ax_r[63:30]) || (|ay_r[63:30]) || (|az_r[63:30]);

  // root / divide unit
  hnn_sd_req_t sd_req;
  logic        sd_done;
  logic [31:0] sd_res;
  logic [44:0] div_num;

  assign sd_req.start   = go_r;
  assign sd_req.is_sqrt = (state_r == ST_SQRT);
  assign div_num = {1'b0, vsel, 14'b0} + 45'(root_r >> 1);

  hnn_sqrt_div u_sd (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sd_req),
    .sq_in   ({2'b0, ssum_r}),
    .div_num (div_num),
    .div_den (root_r),
    .done    (sd_done),
    .result  (sd_res)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire && in_data.func == FUNC_QUERY) state_nxt = ST_FETCH;
      ST_FETCH: if (fcnt_r == 4'd12) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MULX;
      ST_MULX:  state_nxt = ST_MULY;
      ST_MULY:  state_nxt = ST_NORM;
      ST_NORM:  if (!big) state_nxt = ST_SQR;
      ST_SQR:   if (sub_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT:  if (sd_done) state_nxt = ST_DIV;
      ST_DIV:   if (sd_done && sub_r == 2'd2) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_en_r <= 1'b0;
      go_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= (state_r == ST_FETCH) && (fcnt_r < 4'd12);
      go_r     <= ((state_r == ST_SQR) && (sub_r == 2'd2)) ||
                  ((state_r == ST_SQRT) && sd_done) ||
                  ((state_r == ST_DIV) && sd_done && (sub_r != 2'd2));
      if (state_r == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_node_r <= fcnt_r[3:2];
    if (in_fire) begin
      qc_r   <= qc_cl;
      qr_r   <= qr_cl;
      ip1_r  <= (qc_cl < cols_a) ? qc_cl + 9'd1 : cols_a;
      jp1_r  <= (qr_cl < rows_a) ? qr_cl + 9'd1 : rows_a;
      fcnt_r <= '0;
      sum0_r <= '0;
      sum1_r <= '0;
      sum2_r <= '0;
    end else begin
      if (state_r == ST_FETCH && fcnt_r != 4'd12) fcnt_r <= fcnt_r + 4'd1;
      if (acc_en_r) begin
        case (acc_node_r)
          2'd1:    sum1_r <= sum1_r + 34'(signed'(ram_rdata));
          2'd2:    sum2_r <= sum2_r + 34'(signed'(ram_rdata));
          default: sum0_r <= sum0_r + 34'(signed'(ram_rdata));
        endcase
      end
    end
    case (state_r)
      ST_DIFF: begin
        z0_r   <= z0_c;
        adx_r  <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        ady_r  <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
        posx_r <= !dx_c[32] && (dx_c != '0);
        posy_r <= !dy_c[32] && (dy_c != '0);
        az_r   <= UNIT_Q24;
      end
      ST_MULX: ax_r <= mul_p + (adx_r[32] ? {inv_col_r, 32'b0} : 64'd0);
      ST_MULY: ay_r <= mul_p + (ady_r[32] ? {inv_row_r, 32'b0} : 64'd0);
      ST_NORM: begin
        if (big) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
          az_r <= az_r >> 1;
        end
        sub_r  <= 2'd0;
        ssum_r <= '0;
      end
      ST_SQR: begin
        ssum_r <= ssum_r + 62'(mul_p[59:0]);
        sub_r  <= (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
      end
      ST_SQRT: if (sd_done) root_r <= sd_res[30:0];
      ST_DIV: begin
        if (sd_done) begin
          case (sub_r)
            2'd1:    qy_r <= sd_res[14:0];
            2'd2:    qz_r <= sd_res[14:0];
            default: qx_r <= sd_res[14:0];
          endcase
          sub_r <= sub_r + 2'd1;
        end
      end
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) begin
      out_data.node_height <= z0_r;
      out_data.normal_x    <= posx_r ? 16'(17'h10000 - 17'(qx_r)) : 16'(qx_r);
      out_data.normal_y    <= posy_r ? 16'(17'h10000 - 17'(qy_r)) : 16'(qy_r);
      out_data.normal_z    <= qz_r;
    end
  end

  `HNN_ASSERT_NEXT(a_query_holds_input, in_fire && in_data.func == FUNC_QUERY, in_stall)
  `HNN_ASSERT_IMPL(a_result_from_done, $rose(out_valid), $past(state_r == ST_DONE))
  `HNN_ASSERT_IMPL(a_fetch_bound, state_r == ST_FETCH, fcnt_r <= 4'd12)

endmodule

`default_nettype wire

// File: hdl/hnn_cell_ram.sv
// ----------------------------------------------------------------------------
// hnn_cell_ram
// Cell elevation store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hnn_cell_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/hnn_sqrt_div.sv
// ----------------------------------------------------------------------------
// hnn_sqrt_div
// Shared iterative unit: 64-bit integer square root (two bits per step,
// 32 steps) or 45/31-bit restoring divide with a 15-bit quotient (15 steps).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hnn_sqrt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hnn_pkg::hnn_sd_req_t req,
  input  wire logic [63:0]        sq_in,
  input  wire logic [44:0]        div_num,
  input  wire logic [30:0]        div_den,
  output logic                    done,
  output logic [31:0]             result
);
  import hnn_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sqrt_r;
  logic [4:0]  cnt_r;
  logic [63:0] n_r, root_r, bit_r;
  logic [44:0] rem_r, dsh_r;
  logic [14:0] q_r;
  logic [63:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ((sqrt_r && cnt_r == 5'd31) || (!sqrt_r && cnt_r == 5'd14)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_r <= req.is_sqrt;
      cnt_r  <= '0;
      n_r    <= sq_in;
      root_r <= '0;
      bit_r  <= 64'h4000_0000_0000_0000;
      rem_r  <= div_num;
      dsh_r  <= {div_den, 14'b0};
      q_r    <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (sqrt_r) begin
        if (n_r >= trial) begin
          n_r    <= n_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[13:0], 1'b1};
        end else begin
          q_r   <= {q_r[13:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
    end
  end

  assign done   = done_r;
  assign result = sqrt_r ? root_r[31:0] : {17'b0, q_r};

  `HNN_ASSERT_IMPL(a_done_after_busy, done_r, $past(busy_r))
  `HNN_ASSERT_IMPL(a_no_restart, busy_r, !req.start)
  `HNN_ASSERT_IMPL(a_quot_range, done_r && !sqrt_r, q_r <= Q14_ONE)

endmodule

`default_nettype wire
